// ----- hdl/cbsf_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants shared by the cubic Bezier segment flattener.
// No dependencies.
package cbsf_pkg;

   localparam int COORD_BITS = 16;
   localparam int STEP_BITS  = 6;
   localparam int WGT_BITS   = 18;
   localparam int ACC_BITS   = 36;
   localparam int DIV_BITS   = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [STEP_BITS-1:0]  step_type;
   typedef logic        [WGT_BITS-1:0]   wgt_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type out_handle_x;
      coord_type out_handle_y;
      logic      has_out_handle;
      coord_type in_handle_x;
      coord_type in_handle_y;
      logic      has_in_handle;
      coord_type end_x;
      coord_type end_y;
   } seg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CUBE,
      ST_MAC,
      ST_PREP,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                load;
      logic                calc_sq;
      logic                calc_cube;
      logic                mac_en;
      logic [1:0]          mac_sel;
      logic                prep;
      logic                div_en;
      logic [DIV_BITS-1:0] div_shift;
      logic                emit;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic last;
   } status_type;

endpackage

// ----- hdl/cbsf_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces of the flattener.
// Depends on cbsf_pkg.
interface cbsf_req_if import cbsf_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type out_handle_x;
   coord_type out_handle_y;
   logic      has_out_handle;
   coord_type in_handle_x;
   coord_type in_handle_y;
   logic      has_in_handle;
   coord_type end_x;
   coord_type end_y;

   modport source (output valid, start_x, start_y, out_handle_x, out_handle_y,
                   has_out_handle, in_handle_x, in_handle_y, has_in_handle,
                   end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, out_handle_x, out_handle_y,
                 has_out_handle, in_handle_x, in_handle_y, has_in_handle,
                 end_x, end_y, output ready);
endinterface

interface cbsf_rsp_if import cbsf_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

// ----- hdl/cbsf_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the flattener: steps the datapath through weights,
// multiply-accumulate, division and emission for each point. Depends on cbsf_pkg.
module cbsf_ctrl import cbsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type           state_ff, state_in;
   logic [1:0]          mac_ff, mac_in;
   logic [DIV_BITS-1:0] div_ff, div_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mac_ff   <= '0;
         div_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mac_ff   <= mac_in;
         div_ff   <= div_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mac_in   = mac_ff;
      div_in   = div_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SQUARE;
         end
         ST_SQUARE: state_in = ST_CUBE;
         ST_CUBE: begin
            state_in = ST_MAC;
            mac_in   = '0;
         end
         ST_MAC: begin
            mac_in = mac_ff + 2'd1;
            if (mac_ff == 2'd3) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_DIVIDE;
            div_in   = '1;
         end
         ST_DIVIDE: begin
            div_in = div_ff - 1'b1;
            if (div_ff == '0) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.slot_free) state_in = status.last ? ST_IDLE : ST_SQUARE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mac_sel   = mac_ff;
      cmd.div_shift = div_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SQUARE: cmd.calc_sq   = 1'b1;
         ST_CUBE:   cmd.calc_cube = 1'b1;
         ST_MAC:    cmd.mac_en    = 1'b1;
         ST_PREP:   cmd.prep      = 1'b1;
         ST_DIVIDE: cmd.div_en    = 1'b1;
         ST_EMIT:   cmd.emit      = status.slot_free;
         default:   cmd           = '0;
      endcase
   end

endmodule

// ----- hdl/cbsf_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the flattener: control points, Bernstein weights, accumulators,
// two bit-serial dividers and the output register. Depends on cbsf_pkg.
module cbsf_datapath import cbsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  step_type   steps,
   input  seg_type    seg,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output coord_type  point_x,
   output coord_type  point_y,
   output logic       last_point
);

   coord_type px_ff [4];
   coord_type py_ff [4];
   step_type  s_ff, j_ff, u_ff;
   logic [2*STEP_BITS-1:0] u2_ff, j2_ff, s2_ff;
   wgt_type   w_ff [4];
   wgt_type   den_ff;
   acc_type   acc_x_ff, acc_y_ff;
   logic [ACC_BITS-1:0] rem_x_ff, rem_y_ff;
   logic [COORD_BITS-1:0] q_x_ff, q_y_ff;
   logic      rsp_valid_ff;
   coord_type point_x_ff, point_y_ff;
   logic      last_ff;

   step_type  u_now;
   logic signed [WGT_BITS+COORD_BITS:0] prod_x, prod_y;
   logic signed [ACC_BITS:0] n_x, n_y;
   logic [ACC_BITS-1:0] dsh;
   logic [ACC_BITS:0] tr_x, tr_y;

   assign u_now  = s_ff - j_ff;
   assign prod_x = $signed({1'b0, w_ff[cmd.mac_sel]}) * px_ff[cmd.mac_sel];
   assign prod_y = $signed({1'b0, w_ff[cmd.mac_sel]}) * py_ff[cmd.mac_sel];
   // offset by 2^15 divisors keeps the dividend non-negative
   assign n_x = $signed({acc_x_ff, 1'b0}) + $signed({19'b0, den_ff})
              + $signed({3'b0, den_ff, 16'b0});
   assign n_y = $signed({acc_y_ff, 1'b0}) + $signed({19'b0, den_ff})
              + $signed({3'b0, den_ff, 16'b0});
   assign dsh  = ACC_BITS'({den_ff, 1'b0}) << cmd.div_shift;
   assign tr_x = {1'b0, rem_x_ff} - {1'b0, dsh};
   assign tr_y = {1'b0, rem_y_ff} - {1'b0, dsh};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff[0] <= seg.start_x;
         py_ff[0] <= seg.start_y;
         px_ff[1] <= seg.has_out_handle ? seg.out_handle_x : seg.start_x;
         py_ff[1] <= seg.has_out_handle ? seg.out_handle_y : seg.start_y;
         px_ff[2] <= seg.has_in_handle ? seg.in_handle_x : seg.end_x;
         py_ff[2] <= seg.has_in_handle ? seg.in_handle_y : seg.end_y;
         px_ff[3] <= seg.end_x;
         py_ff[3] <= seg.end_y;
         s_ff     <= (steps == '0) ? step_type'(1) : steps;
      end
      if (cmd.calc_sq) begin
         u_ff  <= u_now;
         u2_ff <= u_now * u_now;
         j2_ff <= j_ff * j_ff;
         s2_ff <= s_ff * s_ff;
      end
      if (cmd.calc_cube) begin
         w_ff[0]  <= WGT_BITS'(u2_ff * u_ff);
         w_ff[1]  <= WGT_BITS'(u2_ff * j_ff * 2'd3);
         w_ff[2]  <= WGT_BITS'(j2_ff * u_ff * 2'd3);
         w_ff[3]  <= WGT_BITS'(j2_ff * j_ff);
         den_ff   <= WGT_BITS'(s2_ff * s_ff);
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end
      if (cmd.mac_en) begin
         acc_x_ff <= acc_x_ff + ACC_BITS'(prod_x);
         acc_y_ff <= acc_y_ff + ACC_BITS'(prod_y);
      end
      if (cmd.prep) begin
         rem_x_ff <= n_x[ACC_BITS-1:0];
         rem_y_ff <= n_y[ACC_BITS-1:0];
         q_x_ff   <= '0;
         q_y_ff   <= '0;
      end
      if (cmd.div_en) begin
         if (!tr_x[ACC_BITS]) begin
            rem_x_ff             <= tr_x[ACC_BITS-1:0];
            q_x_ff[cmd.div_shift] <= 1'b1;
         end
         if (!tr_y[ACC_BITS]) begin
            rem_y_ff             <= tr_y[ACC_BITS-1:0];
            q_y_ff[cmd.div_shift] <= 1'b1;
         end
      end
      if (cmd.emit) begin
         point_x_ff <= {~q_x_ff[COORD_BITS-1], q_x_ff[COORD_BITS-2:0]};
         point_y_ff <= {~q_y_ff[COORD_BITS-1], q_y_ff[COORD_BITS-2:0]};
         last_ff    <= status.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) j_ff <= '0;
         else if (cmd.emit) j_ff <= status.last ? step_type'(0) : j_ff + 1'b1;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign status.slot_free = !rsp_valid_ff || rsp_ready;
   assign status.last      = (j_ff == s_ff);
   assign rsp_valid        = rsp_valid_ff;
   assign point_x          = point_x_ff;
   assign point_y          = point_y_ff;
   assign last_point       = last_ff;

endmodule

// ----- hdl/cubic_bezier_segment_flattener.sv -----
`timescale 1ns / 1ps
// Top level of the cubic Bezier segment flattener: steps register, sequencer
// and datapath. Depends on cbsf_pkg, cbsf_if, cbsf_ctrl and cbsf_datapath.
//
// Each request on req_chan is one cubic segment (ends, handles, handle flags).
// The block answers with steps+1 points on rsp_chan, last_point set on the
// final one. The user writes steps through csr_write/csr_wdata only while
// idle; the block itself does not enforce it. 0 acts as 1. Reset sets
// steps to 63 and empties the block. Each point runs through the weight
// states (square, then cube), multiply-accumulate over the four control
// points, a set-up, the one-bit-per-cycle divider over the 16 quotient bits
// and an emit; req_chan.ready is high only between segments.
// Points sit in an output register; while rsp_chan.ready is low the
// next point is computed and then held until the register drains.
module cubic_bezier_segment_flattener import cbsf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write,
   input  step_type        csr_wdata,
   cbsf_req_if.sink        req_chan,
   cbsf_rsp_if.source      rsp_chan
);

   step_type   steps_ff;
   cmd_type    cmd;
   status_type status;
   seg_type    seg;
   logic       req_ready;

   always_ff @(posedge clock) begin
      if (reset) steps_ff <= step_type'(63);
      else if (csr_write) steps_ff <= csr_wdata;
   end

   assign seg.start_x        = req_chan.start_x;
   assign seg.start_y        = req_chan.start_y;
   assign seg.out_handle_x   = req_chan.out_handle_x;
   assign seg.out_handle_y   = req_chan.out_handle_y;
   assign seg.has_out_handle = req_chan.has_out_handle;
   assign seg.in_handle_x    = req_chan.in_handle_x;
   assign seg.in_handle_y    = req_chan.in_handle_y;
   assign seg.has_in_handle  = req_chan.has_in_handle;
   assign seg.end_x          = req_chan.end_x;
   assign seg.end_y          = req_chan.end_y;
   assign req_chan.ready     = req_ready;

   cbsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbsf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .steps      (steps_ff),
      .seg        (seg),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .point_x    (rsp_chan.point_x),
      .point_y    (rsp_chan.point_y),
      .last_point (rsp_chan.last_point)
   );

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_ready |=> !req_ready)
      else $error("request taken while a segment is in progress");

   a_emit_shows_point: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_chan.valid)
      else $error("emitted point not presented");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.calc_sq, cmd.calc_cube, cmd.mac_en, cmd.prep,
                cmd.div_en, cmd.emit}))
      else $error("conflicting datapath commands");

endmodule

// ----- tb/cbsf_tb_if.sv -----
`timescale 1ns / 1ps
// Testbench copy of the flattener channel interfaces is not needed: the RTL
// interfaces in hdl/cbsf_if.sv are used. This file holds the stall pattern helper.
// Depends on nothing.
package cbsf_tb_pkg;
   // receiver stall pattern, one bit per cycle, rotated each cycle
   localparam logic [15:0] STALL_PATTERN = 16'b1011_0011_1110_0101;
endpackage

// ----- tb/cubic_bezier_segment_flattener_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for cubic_bezier_segment_flattener: directed and random
// segments under bursty requests and patterned response stalls, checked point by point.
// Depends on cubic_bezier_segment_flattener, cbsf_pkg, cbsf_if and cbsf_tb_pkg.
module cubic_bezier_segment_flattener_tb;
   import cbsf_pkg::*;
   import cbsf_tb_pkg::*;

   typedef struct {
      coord_type px;
      coord_type py;
      logic      lst;
   } point_type;

   logic     clock = 0;
   logic     reset = 1;
   logic     csr_write = 0;
   step_type csr_wdata = '0;
   cbsf_req_if req_chan ();
   cbsf_rsp_if rsp_chan ();

   cubic_bezier_segment_flattener dut (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_wdata(csr_wdata),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always #6 clock = ~clock;

   point_type   point_queue[$];
   int          steps_cur = 63;
   int          error_count = 0;
   int          point_count = 0;
   int          seg_count = 0;
   logic [15:0] stall_bits = STALL_PATTERN;
   bit          stall_on = 1;

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // exact round-half-up of the Bernstein sum
   function automatic coord_type bezier_coord(input longint p0, p1, p2, p3,
                                              input longint s, j);
      longint u, num, n, d, q;
      u = s - j;
      num = u*u*u*p0 + 3*u*u*j*p1 + 3*u*j*j*p2 + j*j*j*p3;
      n = 2*num + s*s*s;
      d = 2*s*s*s;
      q = n / d;
      if ((n % d) != 0 && n < 0) q -= 1;
      return coord_type'(q);
   endfunction

   function automatic void predict_points(input seg_type sg);
      longint x1, y1, x2, y2, s;
      point_type pt;
      s = (steps_cur < 1) ? 1 : steps_cur;
      x1 = sg.has_out_handle ? sg.out_handle_x : sg.start_x;
      y1 = sg.has_out_handle ? sg.out_handle_y : sg.start_y;
      x2 = sg.has_in_handle ? sg.in_handle_x : sg.end_x;
      y2 = sg.has_in_handle ? sg.in_handle_y : sg.end_y;
      for (longint j = 0; j <= s; j++) begin
         pt.px = bezier_coord(sg.start_x, x1, x2, sg.end_x, s, j);
         pt.py = bezier_coord(sg.start_y, y1, y2, sg.end_y, s, j);
         pt.lst = (j == s);
         point_queue = {point_queue, pt};
      end
   endfunction

   // response stall pattern, with stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
      end else begin
         stall_bits <= {stall_bits[14:0], stall_bits[15]};
         if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
         rsp_chan.ready <= stall_on ? stall_bits[15] : 1'b1;
      end
   end

   always @(posedge clock) begin
      point_type ex;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         point_count++;
         if (point_queue.size() == 0) begin
            report("point with none expected");
         end else begin
            ex = point_queue.pop_front();
            if (rsp_chan.point_x !== ex.px)
               report($sformatf("point_x %0d exp %0d", rsp_chan.point_x, ex.px));
            if (rsp_chan.point_y !== ex.py)
               report($sformatf("point_y %0d exp %0d", rsp_chan.point_y, ex.py));
            if (rsp_chan.last_point !== ex.lst)
               report($sformatf("last_point %0b exp %0b", rsp_chan.last_point, ex.lst));
         end
      end
   end

   task automatic send_segment(input seg_type sg);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 30)) @(posedge clock);
      req_chan.valid <= 1;
      req_chan.start_x <= sg.start_x;
      req_chan.start_y <= sg.start_y;
      req_chan.out_handle_x <= sg.out_handle_x;
      req_chan.out_handle_y <= sg.out_handle_y;
      req_chan.has_out_handle <= sg.has_out_handle;
      req_chan.in_handle_x <= sg.in_handle_x;
      req_chan.in_handle_y <= sg.in_handle_y;
      req_chan.has_in_handle <= sg.has_in_handle;
      req_chan.end_x <= sg.end_x;
      req_chan.end_y <= sg.end_y;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_points(sg);
      seg_count++;
      req_chan.valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (point_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_steps(input int v);
      drain();
      csr_write <= 1;
      csr_wdata <= step_type'(v);
      @(posedge clock);
      csr_write <= 0;
      steps_cur = v;
   endtask

   function automatic seg_type random_segment();
      logic [159:0] raw;
      seg_type sg;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      sg = seg_type'(raw[129:0]);
      return sg;
   endfunction

   task automatic test_directed();
      seg_type sg;
      coord_type ext[4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
      write_steps(4);
      for (int k = 0; k < 16; k++) begin
         sg = random_segment();
         sg.start_x = ext[k % 4];
         sg.start_y = ext[(k + 1) % 4];
         sg.out_handle_x = ext[(k / 4) % 4];
         sg.out_handle_y = ext[(k + 2) % 4];
         sg.in_handle_x = ext[(k + 3) % 4];
         sg.in_handle_y = ext[(k / 4 + 1) % 4];
         sg.end_x = ext[(k + 2) % 4];
         sg.end_y = ext[k % 4];
         sg.has_out_handle = k[0];
         sg.has_in_handle = k[1];
         send_segment(sg);
      end
      // zero steps acts as one
      write_steps(0);
      repeat (3) send_segment(random_segment());
      write_steps(1);
      repeat (2) send_segment(random_segment());
   endtask

   task automatic test_random(input int count, input int lo, input int hi);
      for (int k = 0; k < count; k++) begin
         if (k % 40 == 0) write_steps($urandom_range(lo, hi));
         send_segment(random_segment());
      end
   endtask

   task automatic test_max_steps();
      write_steps(63);
      repeat (6) send_segment(random_segment());
   endtask

   initial begin
      req_chan.valid = 0;
      req_chan.start_x = 0;
      req_chan.start_y = 0;
      req_chan.out_handle_x = 0;
      req_chan.out_handle_y = 0;
      req_chan.has_out_handle = 0;
      req_chan.in_handle_x = 0;
      req_chan.in_handle_y = 0;
      req_chan.has_in_handle = 0;
      req_chan.end_x = 0;
      req_chan.end_y = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // reset value of steps is 63
      repeat (2) send_segment(random_segment());
      test_directed();
      test_random(400, 1, 12);
      test_max_steps();
      drain();
      $display("Covered %0d segments and %0d points, steps 0 to 63.", seg_count,
               point_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("Verification failed");
      $finish;
   end
endmodule
